// ===== rtl/sfa_pkg.sv =====
// Shared types, constants and codes of the segment fit allocator.
package sfa_pkg;

  localparam int unsigned MAX_SEGMENTS = 64;
  localparam int unsigned IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned ADDR_BITS    = 32;
  localparam logic [31:0] TOTAL_RESET  = 32'd65536;

  // item kinds
  localparam logic [1:0] KIND_INIT  = 2'd0;
  localparam logic [1:0] KIND_ALLOC = 2'd1;
  localparam logic [1:0] KIND_FREE  = 2'd2;

  // fit rules
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // result codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_FIT    = 2'd1;
  localparam logic [1:0] ST_NO_OWNER  = 2'd2;
  localparam logic [1:0] ST_TBL_FULL  = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  strategy;
    logic [15:0] owner_id;
    logic [31:0] request_size;
  } sfa_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] start_addr;
  } sfa_out_t;

  // one row of the segment table
  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] size;
    logic                 used;
    logic [15:0]          owner;
  } sfa_entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } sfa_rd_req_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    sfa_entry_t       data;
  } sfa_wr_req_t;

  typedef enum logic [2:0] {
    S_BOOT,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_SPLIT,
    S_SPLIT2,
    S_DONE
  } sfa_state_e;

endpackage

// ===== rtl/sfa_table_ram.sv =====
// Segment table memory: one write port, one read port, registered read data.
module sfa_table_ram (
  input  logic                 clk_i,
  input  sfa_pkg::sfa_rd_req_t rd_i,
  input  sfa_pkg::sfa_wr_req_t wr_i,
  output sfa_pkg::sfa_entry_t  rdata_o
);
  import sfa_pkg::*;

  sfa_entry_t mem [MAX_SEGMENTS];
  sfa_entry_t rdata_q;

  // write one row
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // read one row into the registered read data
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sfa_ctrl.sv =====
// Sequencer: scans the table, picks or finds a segment, shifts rows, writes back.
module sfa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sfa_pkg::sfa_in_t     in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sfa_pkg::sfa_out_t    out_word_o,
  output sfa_pkg::sfa_rd_req_t rd_o,
  output sfa_pkg::sfa_wr_req_t wr_o,
  input  sfa_pkg::sfa_entry_t  rdata_i
);
  import sfa_pkg::*;

  sfa_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]      total_q, total_d;
  sfa_in_t          item_q, item_d;
  // scan and shift pipeline
  logic [CNT_W-1:0] rd_q, rd_d;
  logic             pv_q, pv_d;
  logic [CNT_W-1:0] pidx_q, pidx_d;
  // alloc pick
  logic             pk_v_q, pk_v_d;
  logic [CNT_W-1:0] pk_idx_q, pk_idx_d;
  logic [31:0]      pk_start_q, pk_start_d;
  logic [31:0]      pk_size_q, pk_size_d;
  // free match and neighbors
  logic             fd_q, fd_d;
  logic [CNT_W-1:0] fk_q, fk_d;
  sfa_entry_t       cur_q, cur_d;
  sfa_entry_t       lo_q, lo_d;
  sfa_entry_t       hi_q, hi_d;
  logic             hi_v_q, hi_v_d;
  sfa_entry_t       prev_q, prev_d;
  // shift engine
  logic             sh_act_q, sh_act_d;
  logic             sh_up_q, sh_up_d;
  logic [1:0]       sh_n_q, sh_n_d;
  logic [CNT_W-1:0] sh_end_q, sh_end_d;
  // result and output register
  sfa_out_t         res_q, res_d;
  logic             ov_q, ov_d;
  sfa_out_t         ow_q, ow_d;

  logic       in_acc;
  logic       issue;
  logic       fits, better, hit;
  logic       up_m, lo_m;
  logic [1:0] n_m;
  logic [CNT_W-1:0] dest;
  logic [31:0] sum;
  logic       out_free;

  assign in_acc   = (state_q == S_IDLE) && in_valid_i;
  assign issue    = rd_q < cnt_q;
  assign out_free = !ov_q || !out_stall_i;

  // evaluate the row that arrives during a scan
  always_comb begin
    fits = !rdata_i.used && (rdata_i.size >= item_q.request_size)
           && (item_q.request_size != '0)
           && (item_q.strategy == FIT_FIRST || item_q.strategy == FIT_BEST
               || item_q.strategy == FIT_WORST);
    better = !pk_v_q
             || (item_q.strategy == FIT_BEST && rdata_i.size < pk_size_q)
             || (item_q.strategy == FIT_WORST && rdata_i.size > pk_size_q);
    hit = !fd_q && rdata_i.used && (rdata_i.owner == item_q.owner_id);
  end

  // merge decision for a free
  always_comb begin
    up_m = hi_v_q && !hi_q.used;
    lo_m = (fk_q != '0) && !lo_q.used;
    n_m  = {1'b0, up_m} + {1'b0, lo_m};
    dest = lo_m ? fk_q - 1'b1 : fk_q;
    sum  = cur_q.size + (up_m ? hi_q.size : 32'd0) + (lo_m ? lo_q.size : 32'd0);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_BOOT: state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_word_i.kind == KIND_ALLOC || in_word_i.kind == KIND_FREE) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (!issue && !pv_q) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (item_q.kind == KIND_ALLOC) begin
          if (!pk_v_q || pk_size_q == item_q.request_size
              || cnt_q == CNT_W'(MAX_SEGMENTS)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SHIFT;
          end
        end else if (!fd_q) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (!sh_act_q && !pv_q) state_d = sh_up_q ? S_SPLIT : S_DONE;
      end
      S_SPLIT:  state_d = S_SPLIT2;
      S_SPLIT2: state_d = S_DONE;
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall_o  = (state_q != S_IDLE);
    out_valid_o = ov_q;
    out_word_o  = ow_q;
  end

  // datapath and memory requests
  always_comb begin
    cnt_d      = cnt_q;
    total_d    = cfg_we_i ? cfg_wdata_i : total_q;
    item_d     = item_q;
    rd_d       = rd_q;
    pv_d       = 1'b0;
    pidx_d     = pidx_q;
    pk_v_d     = pk_v_q;
    pk_idx_d   = pk_idx_q;
    pk_start_d = pk_start_q;
    pk_size_d  = pk_size_q;
    fd_d       = fd_q;
    fk_d       = fk_q;
    cur_d      = cur_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    hi_v_d     = hi_v_q;
    prev_d     = prev_q;
    sh_act_d   = sh_act_q;
    sh_up_d    = sh_up_q;
    sh_n_d     = sh_n_q;
    sh_end_d   = sh_end_q;
    res_d      = res_q;
    ov_d       = ov_q && out_stall_i;
    ow_d       = ow_q;
    rd_o       = '0;
    wr_o       = '0;

    case (state_q)
      // build the one free segment after reset
      S_BOOT: begin
        wr_o.en   = 1'b1;
        wr_o.addr = '0;
        wr_o.data = '{start: '0, size: total_q, used: 1'b0, owner: '0};
        cnt_d     = CNT_W'(1);
      end
      S_IDLE: begin
        if (in_acc) begin
          item_d = in_word_i;
          rd_d   = '0;
          pk_v_d = 1'b0;
          fd_d   = 1'b0;
          hi_v_d = 1'b0;
          res_d  = '{status: ST_OK, start_addr: '0};
          if (in_word_i.kind == KIND_INIT) begin
            wr_o.en   = 1'b1;
            wr_o.addr = '0;
            wr_o.data = '{start: '0, size: total_q, used: 1'b0, owner: '0};
            cnt_d     = CNT_W'(1);
          end
        end
      end
      S_SCAN: begin
        // issue the next row read
        rd_o.en   = issue;
        rd_o.addr = rd_q[IDX_W-1:0];
        pv_d      = issue;
        pidx_d    = rd_q;
        if (issue) rd_d = rd_q + 1'b1;
        // judge the row read last cycle
        if (pv_q) begin
          prev_d = rdata_i;
          if (item_q.kind == KIND_ALLOC) begin
            if (fits && better) begin
              pk_v_d     = 1'b1;
              pk_idx_d   = pidx_q;
              pk_start_d = rdata_i.start;
              pk_size_d  = rdata_i.size;
            end
          end else if (hit) begin
            fd_d  = 1'b1;
            fk_d  = pidx_q;
            cur_d = rdata_i;
            lo_d  = prev_q;
          end else if (fd_q && !hi_v_q && pidx_q == fk_q + 1'b1) begin
            hi_v_d = 1'b1;
            hi_d   = rdata_i;
          end
        end
      end
      S_DECIDE: begin
        if (item_q.kind == KIND_ALLOC) begin
          if (!pk_v_q) begin
            res_d = '{status: ST_NO_FIT, start_addr: '0};
          end else if (pk_size_q == item_q.request_size) begin
            // exact fit: mark used, no split
            wr_o.en   = 1'b1;
            wr_o.addr = pk_idx_q[IDX_W-1:0];
            wr_o.data = '{start: pk_start_q, size: pk_size_q, used: 1'b1,
                          owner: item_q.owner_id};
            res_d     = '{status: ST_OK, start_addr: pk_start_q};
          end else if (cnt_q == CNT_W'(MAX_SEGMENTS)) begin
            res_d = '{status: ST_TBL_FULL, start_addr: '0};
          end else begin
            // open a hole above the pick
            sh_up_d  = 1'b1;
            sh_n_d   = 2'd1;
            rd_d     = cnt_q - 1'b1;
            sh_end_d = pk_idx_q + 1'b1;
            sh_act_d = cnt_q > pk_idx_q + 1'b1;
            res_d    = '{status: ST_OK, start_addr: pk_start_q};
          end
        end else if (!fd_q) begin
          res_d = '{status: ST_NO_OWNER, start_addr: '0};
        end else begin
          // write the merged free segment, then close the gap
          wr_o.en   = 1'b1;
          wr_o.addr = dest[IDX_W-1:0];
          wr_o.data = '{start: lo_m ? lo_q.start : cur_q.start, size: sum,
                        used: 1'b0, owner: '0};
          cnt_d     = cnt_q - CNT_W'(n_m);
          sh_up_d   = 1'b0;
          sh_n_d    = n_m;
          rd_d      = dest + 1'b1 + CNT_W'(n_m);
          sh_end_d  = cnt_q - 1'b1;
          sh_act_d  = (n_m != 2'd0) && (dest + 1'b1 + CNT_W'(n_m) <= cnt_q - 1'b1);
          res_d     = '{status: ST_OK, start_addr: '0};
        end
      end
      S_SHIFT: begin
        // read one row, write the row read last cycle to its new place
        rd_o.en   = sh_act_q;
        rd_o.addr = rd_q[IDX_W-1:0];
        pv_d      = sh_act_q;
        pidx_d    = rd_q;
        if (sh_act_q) begin
          if (rd_q == sh_end_q) begin
            sh_act_d = 1'b0;
          end else begin
            rd_d = sh_up_q ? rd_q - 1'b1 : rd_q + 1'b1;
          end
        end
        if (pv_q) begin
          wr_o.en   = 1'b1;
          wr_o.addr = sh_up_q ? IDX_W'(pidx_q + 1'b1)
                              : IDX_W'(pidx_q - CNT_W'(sh_n_q));
          wr_o.data = rdata_i;
        end
      end
      S_SPLIT: begin
        wr_o.en   = 1'b1;
        wr_o.addr = IDX_W'(pk_idx_q + 1'b1);
        wr_o.data = '{start: pk_start_q + item_q.request_size,
                      size: pk_size_q - item_q.request_size, used: 1'b0, owner: '0};
      end
      S_SPLIT2: begin
        wr_o.en   = 1'b1;
        wr_o.addr = pk_idx_q[IDX_W-1:0];
        wr_o.data = '{start: pk_start_q, size: item_q.request_size, used: 1'b1,
                      owner: item_q.owner_id};
        cnt_d     = cnt_q + 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          ov_d = 1'b1;
          ow_d = res_q;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_BOOT;
      cnt_q    <= CNT_W'(1);
      total_q  <= TOTAL_RESET;
      pv_q     <= 1'b0;
      sh_act_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      total_q  <= total_d;
      pv_q     <= pv_d;
      sh_act_q <= sh_act_d;
      ov_q     <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    rd_q       <= rd_d;
    pidx_q     <= pidx_d;
    pk_v_q     <= pk_v_d;
    pk_idx_q   <= pk_idx_d;
    pk_start_q <= pk_start_d;
    pk_size_q  <= pk_size_d;
    fd_q       <= fd_d;
    fk_q       <= fk_d;
    cur_q      <= cur_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    hi_v_q     <= hi_v_d;
    prev_q     <= prev_d;
    sh_up_q    <= sh_up_d;
    sh_n_q     <= sh_n_d;
    sh_end_q   <= sh_end_d;
    res_q      <= res_d;
    ow_q       <= ow_d;
  end

endmodule

// ===== rtl/segment_fit_allocator.sv =====
// Top level of the segment fit allocator.
//
//  channel | direction | handshake              | word
//  in      | input     | in_valid_i / in_stall_o | in_word_i (kind, strategy, owner, size)
//  out     | output    | out_valid_o / out_stall_i | out_word_o (status, start_addr)
//  cfg     | input     | cfg_we_i                | cfg_wdata_i (total_size)
//
// One item at a time. Alloc and free scan all N live rows through the table's
// read port and decide; a split or a merge then shifts rows one per cycle where
// rows must move, and a split writes its two rows last. Init and unused kinds
// go straight to the finishing step. After reset the block writes the initial
// row before it accepts a word. A finished word waits in the output register
// while the next input word is accepted; a stalled output holds only the
// finishing step.
module segment_fit_allocator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sfa_pkg::sfa_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sfa_pkg::sfa_out_t out_word_o
);
  import sfa_pkg::*;

  sfa_rd_req_t rd;
  sfa_wr_req_t wr;
  sfa_entry_t  rdata;

  sfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .rd_o        (rd),
    .wr_o        (wr),
    .rdata_i     (rdata)
  );

  sfa_table_ram u_ram (
    .clk_i   (clk_i),
    .rd_i    (rd),
    .wr_i    (wr),
    .rdata_o (rdata)
  );

endmodule

// ===== rtl/sfa_checker.sv =====
// Port-level checks of the segment fit allocator, bound to the top level.
module sfa_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input sfa_pkg::sfa_out_t out_word_o
);
  import sfa_pkg::*;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word dropped or changed");

  // one word at a time: stall right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while an item is in work");

  // a failed item carries a zero address
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status != ST_OK |-> out_word_o.start_addr == '0)
    else $error("nonzero address on a failed item");

  // a result never appears without work in flight
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o ##1 out_valid_o |-> $past(in_stall_o))
    else $error("result word with no item in work");

endmodule

bind segment_fit_allocator sfa_checker u_sfa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
